FILE: sv/eil_pkg.sv
// ----------------------------------------------------------------------------
// eil_pkg
// Law and status codes and the request and result beat types of the
// interpolation-law unit.
// ----------------------------------------------------------------------------
package eil_pkg;

   // interpolation laws
   localparam logic [2:0] LAW_HIST    = 3'd1;
   localparam logic [2:0] LAW_LIN_LIN = 3'd2;
   localparam logic [2:0] LAW_LIN_LOG = 3'd3;
   localparam logic [2:0] LAW_LOG_LIN = 3'd4;
   localparam logic [2:0] LAW_LOG_LOG = 3'd5;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_LAW  = 3'd1;
   localparam logic [2:0] ST_ZERO_INT = 3'd2;
   localparam logic [2:0] ST_BAD_LOG  = 3'd3;
   localparam logic [2:0] ST_SAT      = 3'd4;

   // request beat
   typedef struct packed {
      logic [31:0]        x_lo;
      logic [31:0]        x_hi;
      logic signed [31:0] y_lo;
      logic signed [31:0] y_hi;
      logic [31:0]        x_query;
      logic [2:0]         law;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [31:0] y_out;
      logic [2:0]         status;
   } rsp_type;

endpackage

FILE: sv/endf_interpolation_laws_unit.sv
// ----------------------------------------------------------------------------
// endf_interpolation_laws_unit
// Fixed-point interpolation by laws 1 to 5 (histogram, lin-lin, lin-log,
// log-lin, log-log) with log2, restoring division and square-root based
// powers of two, all in one long pipeline.
//
//   channel  ports                            beat
//   req      req_valid, req_ready, req_data   one request, eil_pkg::req_type
//   rsp      rsp_valid, rsp_ready, rsp_data   one result, eil_pkg::rsp_type
//
// One request per cycle sustained while no result is waiting at rsp.
// Depth is set by the power-of-two section: FRAC_BITS square roots of
// 32 digit steps each, one digit per stage; the log2 lanes add FRAC_BITS
// stages and the divider 32+FRAC_BITS.
// Reset clears the stage valid bits only.
// rsp_ready low with a result waiting freezes every stage; req_ready follows.
// ----------------------------------------------------------------------------
module endf_interpolation_laws_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eil_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eil_pkg::rsp_type rsp_data
);

   localparam int QW  = 32 + FRAC_BITS;
   localparam int LW  = FRAC_BITS + 7;
   localparam int P1W = 32 + FRAC_BITS;
   localparam int PW  = 64 + FRAC_BITS;
   localparam int NSQ = 32 * FRAC_BITS;

   localparam logic signed [7:0] IP_MAX = 8'sd70;
   localparam logic signed [7:0] IP_MIN = -8'sd40;

   // per-item control that rides along every stage
   typedef struct packed {
      logic [2:0]  law;
      logic [2:0]  st;
      logic        done;
      logic [31:0] y_lo;
      logic [31:0] y_res;
   } ctx_type;

   typedef struct packed {
      ctx_type                      c;
      logic [31:0]                  x_lo;
      logic [31:0]                  x_hi;
      logic [31:0]                  x_query;
      logic [31:0]                  y_hi;
      logic [4:0][4:0]              lp;
      logic [4:0][30:0]             lm;
      logic [4:0][FRAC_BITS-1:0]    lf;
   } lg_type;

   typedef struct packed {
      ctx_type          c;
      logic             sq;
      logic             sc;
      logic [31:0]      num;
      logic [31:0]      bmag;
      logic [31:0]      cmag;
      logic [31:0]      rem;
      logic [QW-1:0]    q;
   } dv_type;

   typedef struct packed {
      ctx_type          c;
      logic             sm;
      logic [63:0]      p0;
      logic [P1W-1:0]   p1;
   } mu1_type;

   typedef struct packed {
      ctx_type          c;
      logic             sm;
      logic [62:0]      mm;
   } mu2_type;

   typedef struct packed {
      ctx_type                c;
      logic signed [7:0]      ipc;
      logic [FRAC_BITS-1:0]   fp;
      logic [33:0]            rad;
      logic [31:0]            root;
      logic [32:0]            rem;
   } pw_type;

   typedef struct packed {
      ctx_type                c;
      logic signed [7:0]      ipc;
      logic [63:0]            p;
   } fh_type;

   // helpers
   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int b = 0; b < 32; b++) begin
         if (v[b]) p = 5'(b);
      end
      return p;
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] t;
      t = v[32] ? (~v + 33'd1) : v;
      return t[31:0];
   endfunction

   // one squaring round of log2 on all five lanes
   function automatic lg_type lg_step(input lg_type cur);
      lg_type      n;
      logic [61:0] sq;
      logic [31:0] m2;
      n = cur;
      for (int k = 0; k < 5; k++) begin
         sq = {31'b0, cur.lm[k]} * {31'b0, cur.lm[k]};
         m2 = sq[61:30];
         n.lm[k] = m2[31] ? m2[31:1] : m2[30:0];
         n.lf[k] = {cur.lf[k][FRAC_BITS-2:0], m2[31]};
      end
      return n;
   endfunction

   // one restoring quotient bit
   function automatic dv_type dv_step(input dv_type cur);
      dv_type      n;
      logic [32:0] r2;
      logic [32:0] df;
      logic        ge;
      n  = cur;
      r2 = {cur.rem, cur.num[31]};
      df = r2 - {1'b0, cur.bmag};
      ge = r2 >= {1'b0, cur.bmag};
      n.rem = ge ? df[31:0] : r2[31:0];
      n.num = {cur.num[30:0], 1'b0};
      n.q   = {cur.q[QW-2:0], ge};
      return n;
   endfunction

   // one square-root digit; first opens a new root on the scaled r
   function automatic pw_type pw_step(input pw_type cur, input logic first);
      pw_type      n;
      logic [32:0] rpre;
      logic [33:0] rad;
      logic [31:0] root;
      logic [32:0] rem;
      logic [34:0] r4;
      logic [34:0] tr;
      logic [34:0] df;
      logic        ge;
      n = cur;
      if (first) begin
         rpre = cur.fp[0] ? {cur.root, 1'b0} : {1'b0, cur.root};
         rad  = {1'b0, rpre};
         root = '0;
         rem  = '0;
         n.fp = cur.fp >> 1;
      end else begin
         rpre = '0;
         rad  = cur.rad;
         root = cur.root;
         rem  = cur.rem;
      end
      r4 = {rem, rad[33:32]};
      tr = {1'b0, root, 2'b01};
      df = r4 - tr;
      ge = r4 >= tr;
      n.rem  = ge ? df[32:0] : r4[32:0];
      n.root = {root[30:0], ge};
      n.rad  = {rad[31:0], 2'b00};
      return n;
   endfunction

   // pipeline registers
   eil_pkg::req_type   in_ff;
   logic               in_v_ff;
   lg_type             lg_ff [0:FRAC_BITS];
   lg_type             lg_in [0:FRAC_BITS-1];
   lg_type             lg0_in;
   logic [FRAC_BITS:0] lg_v_ff;
   dv_type             dv_ff [0:QW];
   dv_type             dv_in [0:QW-1];
   dv_type             dv0_in;
   logic [QW:0]        dv_v_ff;
   mu1_type            mu1_ff, mu1_in;
   logic               mu1_v_ff;
   mu2_type            mu2_ff, mu2_in;
   logic               mu2_v_ff;
   pw_type             pw_ff [0:NSQ];
   pw_type             pw_in [0:NSQ-1];
   pw_type             pw0_in;
   logic [NSQ:0]       pw_v_ff;
   fh_type             fh_ff, fh_in;
   logic               fh_v_ff;
   eil_pkg::rsp_type   out_ff, out_in;
   logic               out_v_ff;
   logic               advance;

   // whole pipe moves unless a result is waiting
   assign advance   = !out_v_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // decode, early checks and log2 normalization
   always_comb begin
      logic             lx;
      logic             ly;
      logic [4:0][31:0] v;
      logic [31:0]      sh;
      lg0_in = '0;
      lx = (in_ff.law == eil_pkg::LAW_LIN_LOG) || (in_ff.law == eil_pkg::LAW_LOG_LOG);
      ly = (in_ff.law == eil_pkg::LAW_LOG_LIN) || (in_ff.law == eil_pkg::LAW_LOG_LOG);
      lg0_in.x_lo    = in_ff.x_lo;
      lg0_in.x_hi    = in_ff.x_hi;
      lg0_in.x_query = in_ff.x_query;
      lg0_in.y_hi    = in_ff.y_hi;
      lg0_in.c.law   = in_ff.law;
      lg0_in.c.y_lo  = in_ff.y_lo;
      lg0_in.c.y_res = '0;
      priority if (!(in_ff.law == eil_pkg::LAW_HIST || in_ff.law == eil_pkg::LAW_LIN_LIN ||
                     in_ff.law == eil_pkg::LAW_LIN_LOG || in_ff.law == eil_pkg::LAW_LOG_LIN ||
                     in_ff.law == eil_pkg::LAW_LOG_LOG)) begin
         lg0_in.c.st   = eil_pkg::ST_BAD_LAW;
         lg0_in.c.done = 1'b1;
      end else if (in_ff.law == eil_pkg::LAW_HIST) begin
         lg0_in.c.st    = eil_pkg::ST_OK;
         lg0_in.c.done  = 1'b1;
         lg0_in.c.y_res = in_ff.y_lo;
      end else if (in_ff.x_lo == in_ff.x_hi) begin
         lg0_in.c.st   = eil_pkg::ST_ZERO_INT;
         lg0_in.c.done = 1'b1;
      end else if (lx && (in_ff.x_lo == '0 || in_ff.x_hi == '0 || in_ff.x_query == '0)) begin
         lg0_in.c.st   = eil_pkg::ST_BAD_LOG;
         lg0_in.c.done = 1'b1;
      end else if (ly && (in_ff.y_lo == '0 || in_ff.y_hi == '0 ||
                          in_ff.y_lo[31] != in_ff.y_hi[31])) begin
         lg0_in.c.st   = eil_pkg::ST_BAD_LOG;
         lg0_in.c.done = 1'b1;
      end else begin
         lg0_in.c.st   = eil_pkg::ST_OK;
         lg0_in.c.done = 1'b0;
      end
      // lanes: x_hi, x_lo, x_query, |y_hi|, |y_lo|
      v[0] = in_ff.x_hi;
      v[1] = in_ff.x_lo;
      v[2] = in_ff.x_query;
      v[3] = abs32(in_ff.y_hi);
      v[4] = abs32(in_ff.y_lo);
      for (int k = 0; k < 5; k++) begin
         lg0_in.lp[k] = msb_pos(v[k]);
         sh = v[k] << (5'd30 - lg0_in.lp[k]);
         lg0_in.lm[k] = (lg0_in.lp[k] == 5'd31) ? v[k][31:1] : sh[30:0];
         lg0_in.lf[k] = '0;
      end
   end

   // log2 squaring stages
   for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
      assign lg_in[g] = lg_step(lg_ff[g]);
   end

   // log differences, late zero-interval check, divider operands
   always_comb begin
      lg_type                  lg;
      logic [4:0][LW-1:0]      lv;
      logic signed [LW-1:0]    lh;
      logic signed [LW-1:0]    lq;
      logic signed [LW-1:0]    dd;
      logic signed [32:0]      lh33;
      logic signed [32:0]      lq33;
      logic signed [32:0]      dd33;
      logic [32:0]             dx;
      logic [32:0]             den;
      logic [32:0]             dy;
      logic [32:0]             a;
      logic [32:0]             b;
      logic [32:0]             c;
      logic                    lx;
      lg = lg_ff[FRAC_BITS];
      for (int k = 0; k < 5; k++) begin
         lv[k] = {7'(lg.lp[k]) - 7'(FRAC_BITS), lg.lf[k]};
      end
      lh   = $signed(lv[0]) - $signed(lv[1]);
      lq   = $signed(lv[2]) - $signed(lv[1]);
      dd   = $signed(lv[3]) - $signed(lv[4]);
      lh33 = 33'(lh);
      lq33 = 33'(lq);
      dd33 = 33'(dd);
      dx   = {1'b0, lg.x_query} - {1'b0, lg.x_lo};
      den  = {1'b0, lg.x_hi} - {1'b0, lg.x_lo};
      dy   = {lg.y_hi[31], lg.y_hi} - {lg.c.y_lo[31], lg.c.y_lo};
      lx   = (lg.c.law == eil_pkg::LAW_LIN_LOG) || (lg.c.law == eil_pkg::LAW_LOG_LOG);
      dv0_in   = '0;
      dv0_in.c = lg.c;
      if (!lg.c.done && lx && lh == '0) begin
         dv0_in.c.st   = eil_pkg::ST_ZERO_INT;
         dv0_in.c.done = 1'b1;
      end
      a = (lg.c.law == eil_pkg::LAW_LIN_LOG) ? lq33 :
          (lg.c.law == eil_pkg::LAW_LOG_LOG) ? dd33 : dx;
      b = lx ? lh33 : den;
      c = (lg.c.law == eil_pkg::LAW_LOG_LIN) ? dd33 :
          (lg.c.law == eil_pkg::LAW_LOG_LOG) ? lq33 : dy;
      dv0_in.sq   = a[32] ^ b[32];
      dv0_in.sc   = c[32];
      dv0_in.num  = mag33(a);
      dv0_in.bmag = mag33(b);
      dv0_in.cmag = mag33(c);
   end

   // restoring divider, one quotient bit per stage
   for (genvar g = 0; g < QW; g++) begin : g_div
      assign dv_in[g] = dv_step(dv_ff[g]);
   end

   // partial products of operand times quotient
   always_comb begin
      dv_type d;
      d = dv_ff[QW];
      mu1_in.c  = d.c;
      mu1_in.sm = d.sq ^ d.sc;
      mu1_in.p0 = 64'(d.cmag) * 64'(d.q[31:0]);
      mu1_in.p1 = P1W'(d.cmag) * P1W'(d.q[QW-1:32]);
   end

   // sum, drop fraction bits, cap at 2^62
   always_comb begin
      logic [PW-1:0] prod;
      logic [63:0]   sh;
      prod = PW'(mu1_ff.p0) + (PW'(mu1_ff.p1) << 32);
      sh   = prod[PW-1:FRAC_BITS];
      mu2_in.c  = mu1_ff.c;
      mu2_in.sm = mu1_ff.sm;
      mu2_in.mm = (sh > 64'h4000_0000_0000_0000) ? 63'h4000_0000_0000_0000 : sh[62:0];
   end

   // linear laws finish here; log-y laws split the exponent
   always_comb begin
      logic [63:0]        mm64;
      logic signed [63:0] mms;
      logic signed [63:0] ysum;
      logic signed [63:0] ipf;
      mm64 = {1'b0, mu2_ff.mm};
      mms  = $signed(mu2_ff.sm ? (~mm64 + 64'd1) : mm64);
      ysum = $signed({{32{mu2_ff.c.y_lo[31]}}, mu2_ff.c.y_lo}) + mms;
      ipf  = mms >>> FRAC_BITS;
      pw0_in      = '0;
      pw0_in.c    = mu2_ff.c;
      pw0_in.fp   = mms[FRAC_BITS-1:0];
      pw0_in.root = 32'h4000_0000;
      priority if (ipf > 64'(IP_MAX)) pw0_in.ipc = IP_MAX;
      else if (ipf < 64'(IP_MIN))     pw0_in.ipc = IP_MIN;
      else                            pw0_in.ipc = ipf[7:0];
      if (!mu2_ff.c.done && (mu2_ff.c.law == eil_pkg::LAW_LIN_LIN ||
                             mu2_ff.c.law == eil_pkg::LAW_LIN_LOG)) begin
         pw0_in.c.done = 1'b1;
         priority if (ysum > 64'sd2147483647) begin
            pw0_in.c.y_res = 32'h7FFF_FFFF;
            pw0_in.c.st    = eil_pkg::ST_SAT;
         end else if (ysum < -64'sd2147483648) begin
            pw0_in.c.y_res = 32'h8000_0000;
            pw0_in.c.st    = eil_pkg::ST_SAT;
         end else begin
            pw0_in.c.y_res = ysum[31:0];
            pw0_in.c.st    = eil_pkg::ST_OK;
         end
      end
   end

   // power of two of the fraction: square-root digit stages
   for (genvar g = 0; g < NSQ; g++) begin : g_pow
      localparam logic FIRST = ((g % 32) == 0);
      assign pw_in[g] = pw_step(pw_ff[g], FIRST);
   end

   // magnitude of y_lo times the root
   always_comb begin
      fh_in.c   = pw_ff[NSQ].c;
      fh_in.ipc = pw_ff[NSQ].ipc;
      fh_in.p   = 64'(abs32(pw_ff[NSQ].c.y_lo)) * 64'(pw_ff[NSQ].root);
   end

   // integer-part shift, sign and saturation
   always_comb begin
      logic signed [7:0] s;
      logic signed [7:0] ns;
      logic signed [7:0] rs;
      logic [63:0]       mag;
      logic              neg;
      s   = fh_ff.ipc - 8'sd30;
      ns  = -s;
      rs  = 8'sd32 - s;
      neg = fh_ff.c.y_lo[31];
      priority if (s <= 8'sd0) begin
         mag = (s <= -8'sd64) ? 64'd0 : (fh_ff.p >> ns[5:0]);
      end else if (fh_ff.p == '0) begin
         mag = '0;
      end else if (s >= 8'sd32) begin
         mag = 64'h2_0000_0000;
      end else if ((fh_ff.p >> rs[5:0]) != '0) begin
         mag = 64'h2_0000_0000;
      end else begin
         mag = fh_ff.p << s[4:0];
      end
      if (fh_ff.c.done) begin
         out_in.y_out  = fh_ff.c.y_res;
         out_in.status = fh_ff.c.st;
      end else if (!neg && mag > 64'd2147483647) begin
         out_in.y_out  = 32'h7FFF_FFFF;
         out_in.status = eil_pkg::ST_SAT;
      end else if (neg && mag > 64'd2147483648) begin
         out_in.y_out  = 32'h8000_0000;
         out_in.status = eil_pkg::ST_SAT;
      end else begin
         out_in.y_out  = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
         out_in.status = eil_pkg::ST_OK;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         lg_v_ff  <= '0;
         dv_v_ff  <= '0;
         mu1_v_ff <= 1'b0;
         mu2_v_ff <= 1'b0;
         pw_v_ff  <= '0;
         fh_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         in_v_ff  <= req_valid;
         lg_v_ff  <= {lg_v_ff[FRAC_BITS-1:0], in_v_ff};
         dv_v_ff  <= {dv_v_ff[QW-1:0], lg_v_ff[FRAC_BITS]};
         mu1_v_ff <= dv_v_ff[QW];
         mu2_v_ff <= mu1_v_ff;
         pw_v_ff  <= {pw_v_ff[NSQ-1:0], mu2_v_ff};
         fh_v_ff  <= pw_v_ff[NSQ];
         out_v_ff <= fh_v_ff;
      end
      if (advance) begin
         in_ff    <= req_data;
         lg_ff[0] <= lg0_in;
         for (int g = 0; g < FRAC_BITS; g++) lg_ff[g+1] <= lg_in[g];
         dv_ff[0] <= dv0_in;
         for (int g = 0; g < QW; g++) dv_ff[g+1] <= dv_in[g];
         mu1_ff   <= mu1_in;
         mu2_ff   <= mu2_in;
         pw_ff[0] <= pw0_in;
         for (int g = 0; g < NSQ; g++) pw_ff[g+1] <= pw_in[g];
         fh_ff    <= fh_in;
         out_ff   <= out_in;
      end
   end

endmodule
